FILE: hdl/mrte_pkg.sv
// types, constants and helpers shared by the mesh routing table engine
// no dependencies
package mrte_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam logic [7:0] ADV_LIMIT = 8'd16;

    localparam logic [7:0] CFG_OWN_ADDRESS      = 8'd0;
    localparam logic [7:0] CFG_SIGNAL_THRESHOLD = 8'd1;
    localparam logic [7:0] CFG_ROUTE_TIMEOUT    = 8'd2;
    localparam logic [7:0] CFG_HIGHEST_ADDRESS  = 8'd3;

    typedef enum logic [1:0] {
        KIND_AGE_TICK = 2'd0,
        KIND_BEACON   = 2'd1,
        KIND_ENTRY    = 2'd2,
        KIND_DUMP     = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_DONE      = 4'd0,
        ST_WEAK      = 4'd1,
        ST_OWN       = 4'd2,
        ST_BAD_TABLE = 4'd3,
        ST_IGNORED   = 4'd4,
        ST_UPDATED   = 4'd5,
        ST_ADDED     = 4'd6,
        ST_UNCHANGED = 4'd7,
        ST_EMPTY     = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AGE_RD,
        S_AGE_WB,
        S_AGE_FIN,
        S_HDR,
        S_ENT,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RESOLVE,
        S_DUMP_RD,
        S_DUMP_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        sender_addr;
        logic signed [7:0] rx_level;
        logic [7:0]        advertised_count;
        logic              table_ok;
        logic [7:0]        entry_destination;
        logic [7:0]        entry_next_hop;
        logic [7:0]        entry_hops;
    } t_in_item;

    typedef struct packed {
        logic [3:0]       status;
        logic [7:0]       route_destination;
        logic [7:0]       route_next_hop;
        logic [7:0]       route_hops;
        logic [7:0]       route_age;
        logic [CNT_W-1:0] used_entries;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] data;
    } t_cfg_item;

    function automatic logic [31:0] pack_route(logic [7:0] d, logic [7:0] n,
                                               logic [7:0] h, logic [7:0] a);
        return {a, h, n, d};
    endfunction

endpackage

FILE: hdl/mrte_if.sv
// valid/ready channel interfaces of the mesh routing table engine
// depends on mrte_pkg
interface mrte_in_if;
    logic                valid;
    logic                ready;
    mrte_pkg::t_in_item  item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface mrte_out_if;
    logic                valid;
    logic                ready;
    mrte_pkg::t_out_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface mrte_cfg_if;
    logic                valid;
    logic                ready;
    mrte_pkg::t_cfg_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: hdl/mesh_routing_table_engine.sv
// mesh routing table engine top level: table memory and sequencer
// depends on mrte_pkg and mrte_if
//
// Keeps up to sixteen routes (destination, next hop, hops, age) in a small
// synchronous memory with a registered read port. One item is worked on at a
// time; the input is ready again only after the last result of the previous
// item has been loaded into the output register. Each table visit is a read
// followed by a compare or a write back: an age tick visits every stored
// route, a beacon header or advertised entry searches and then does one
// read-modify-write, and a dump visits each listed route (at most 16). The
// output register lets the next item be taken while the final result still
// waits. Configuration writes are always accepted and should come while idle.
module mesh_routing_table_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mrte_in_if.sink      i_in,
    mrte_out_if.source   o_out,
    mrte_cfg_if.sink     i_cfg
);

    localparam int D = mrte_pkg::TABLE_DEPTH;
    localparam int IW = mrte_pkg::IDX_W;
    localparam int CW = mrte_pkg::CNT_W;

    // configuration registers
    logic [7:0]        r_own;
    logic signed [7:0] r_thresh;
    logic [7:0]        r_timeout;
    logic [7:0]        r_highest;

    // route memory, packed {age, hops, next hop, destination}
    logic [31:0] r_mem [D];
    logic [31:0] r_rd_data;
    logic        mem_re;
    logic [IW-1:0] mem_raddr;
    logic        mem_we;
    logic [IW-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    // sequencer and table state
    mrte_pkg::t_state    r_state, n_state;
    mrte_pkg::t_in_item  r_item, n_item;
    logic [CW-1:0]       r_total, n_total;
    logic                r_open, n_open;
    logic [7:0]          r_sender, n_sender;
    logic [7:0]          r_seen, n_seen;
    logic [IW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_wr, n_wr;
    logic                r_found, n_found;
    logic                r_out_valid, n_out_valid;
    mrte_pkg::t_out_item r_out, n_out;

    logic slot_free;
    logic in_acc;
    logic at_end;
    logic [7:0] key;
    logic [7:0] age_inc;
    logic [8:0] hop_plus;
    logic filtered;
    mrte_pkg::t_status hdr_status;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == mrte_pkg::S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    // output register can take a result this cycle
    assign slot_free = !r_out_valid || o_out.ready;

    // current visit is the last stored route
    assign at_end = ({1'b0, r_idx} == r_total - CW'(1));

    assign key = (r_item.kind == mrte_pkg::KIND_BEACON) ? r_item.sender_addr
                                                        : r_item.entry_destination;
    // saturating age increment
    assign age_inc  = (r_rd_data[31:24] == 8'hFF) ? 8'hFF : r_rd_data[31:24] + 8'd1;
    assign hop_plus = {1'b0, r_item.entry_hops} + 9'd1;

    // advertised entry screening
    assign filtered = (r_item.entry_destination == 8'd0 && r_item.entry_next_hop == 8'd0
                       && r_item.entry_hops == 8'd0)
                   || r_item.entry_destination == 8'd0
                   || r_item.entry_destination > r_highest
                   || r_item.entry_next_hop == 8'd0
                   || r_item.entry_next_hop > r_highest
                   || r_item.entry_destination == r_own;

    // beacon header screening, checked in priority order
    always_comb begin
        if (r_item.advertised_count > mrte_pkg::ADV_LIMIT) begin
            hdr_status = mrte_pkg::ST_BAD_TABLE;
        end else if (r_item.advertised_count != 8'd0 && !r_item.table_ok) begin
            hdr_status = mrte_pkg::ST_BAD_TABLE;
        end else if (r_item.rx_level < r_thresh) begin
            hdr_status = mrte_pkg::ST_WEAK;
        end else if (r_item.sender_addr == r_own) begin
            hdr_status = mrte_pkg::ST_OWN;
        end else begin
            hdr_status = mrte_pkg::ST_DONE;
        end
    end

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own     <= 8'd1;
            r_thresh  <= -8'sd100;
            r_timeout <= 8'd5;
            r_highest <= 8'd254;
        end else if (i_cfg.valid) begin
            case (i_cfg.item.index)
                mrte_pkg::CFG_OWN_ADDRESS:      r_own     <= i_cfg.item.data;
                mrte_pkg::CFG_SIGNAL_THRESHOLD: r_thresh  <= i_cfg.item.data;
                mrte_pkg::CFG_ROUTE_TIMEOUT:    r_timeout <= i_cfg.item.data;
                mrte_pkg::CFG_HIGHEST_ADDRESS:  r_highest <= i_cfg.item.data;
                default: ;
            endcase
        end
    end

    // route memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrte_pkg::S_IDLE;
            r_total     <= '0;
            r_open      <= 1'b0;
            r_sender    <= 8'd0;
            r_seen      <= 8'd0;
            r_idx       <= '0;
            r_wr        <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_open      <= n_open;
            r_sender    <= n_sender;
            r_seen      <= n_seen;
            r_idx       <= n_idx;
            r_wr        <= n_wr;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_item <= n_item;
        r_out  <= n_out;
    end

    // sequencer: next state, memory control and result forming
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_total     = r_total;
        n_open      = r_open;
        n_sender    = r_sender;
        n_seen      = r_seen;
        n_idx       = r_idx;
        n_wr        = r_wr;
        n_found     = r_found;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        mem_re      = 1'b0;
        mem_raddr   = r_idx;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = 32'd0;

        case (r_state)
            mrte_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_item = i_in.item;
                    n_idx  = '0;
                    n_wr   = '0;
                    case (i_in.item.kind)
                        mrte_pkg::KIND_AGE_TICK: begin
                            n_state = (r_total == '0) ? mrte_pkg::S_AGE_FIN
                                                      : mrte_pkg::S_AGE_RD;
                        end
                        mrte_pkg::KIND_BEACON: n_state = mrte_pkg::S_HDR;
                        mrte_pkg::KIND_ENTRY:  n_state = mrte_pkg::S_ENT;
                        default:               n_state = mrte_pkg::S_DUMP_RD;
                    endcase
                end
            end

            // age tick: compact the table in place, read index leads write index
            mrte_pkg::S_AGE_RD: begin
                mem_re  = 1'b1;
                n_state = mrte_pkg::S_AGE_WB;
            end
            mrte_pkg::S_AGE_WB: begin
                if (age_inc <= r_timeout) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr[IW-1:0];
                    mem_wdata = {age_inc, r_rd_data[23:0]};
                    n_wr      = r_wr + CW'(1);
                end
                if (at_end) begin
                    n_state = mrte_pkg::S_AGE_FIN;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = mrte_pkg::S_AGE_RD;
                end
            end
            mrte_pkg::S_AGE_FIN: begin
                if (slot_free) begin
                    n_total     = r_wr;
                    n_out       = '{status: mrte_pkg::ST_DONE, route_destination: 8'd0,
                                    route_next_hop: 8'd0, route_hops: 8'd0,
                                    route_age: 8'd0, used_entries: r_wr, last: 1'b1};
                    n_out_valid = 1'b1;
                    n_state     = mrte_pkg::S_IDLE;
                end
            end

            // beacon header: reject or look up the sender
            mrte_pkg::S_HDR: begin
                if (hdr_status != mrte_pkg::ST_DONE) begin
                    if (slot_free) begin
                        n_open      = 1'b0;
                        n_seen      = 8'd0;
                        n_out       = '{status: hdr_status,
                                        route_destination: r_item.sender_addr,
                                        route_next_hop: 8'd0, route_hops: 8'd0,
                                        route_age: 8'd0, used_entries: r_total, last: 1'b1};
                        n_out_valid = 1'b1;
                        n_state     = mrte_pkg::S_IDLE;
                    end
                end else if (r_total == '0) begin
                    n_found = 1'b0;
                    n_state = mrte_pkg::S_RESOLVE;
                end else begin
                    n_state = mrte_pkg::S_SRCH_RD;
                end
            end

            // advertised entry: count it against the open beacon, then screen
            mrte_pkg::S_ENT: begin
                if (!r_open) begin
                    if (slot_free) begin
                        n_out       = '{status: mrte_pkg::ST_IGNORED,
                                        route_destination: r_item.entry_destination,
                                        route_next_hop: r_item.entry_next_hop,
                                        route_hops: r_item.entry_hops,
                                        route_age: 8'd0, used_entries: r_total, last: 1'b1};
                        n_out_valid = 1'b1;
                        n_state     = mrte_pkg::S_IDLE;
                    end
                end else if (!filtered || slot_free) begin
                    n_seen = (r_seen != 8'd0) ? r_seen - 8'd1 : 8'd0;
                    n_open = (n_seen != 8'd0);
                    if (filtered) begin
                        n_out       = '{status: mrte_pkg::ST_IGNORED,
                                        route_destination: r_item.entry_destination,
                                        route_next_hop: r_item.entry_next_hop,
                                        route_hops: r_item.entry_hops,
                                        route_age: 8'd0, used_entries: r_total, last: 1'b1};
                        n_out_valid = 1'b1;
                        n_state     = mrte_pkg::S_IDLE;
                    end else if (r_total == '0) begin
                        n_found = 1'b0;
                        n_state = mrte_pkg::S_RESOLVE;
                    end else begin
                        n_state = mrte_pkg::S_SRCH_RD;
                    end
                end
            end

            // linear search for the destination, a read and then a compare per route
            mrte_pkg::S_SRCH_RD: begin
                mem_re  = 1'b1;
                n_state = mrte_pkg::S_SRCH_CMP;
            end
            mrte_pkg::S_SRCH_CMP: begin
                if (r_rd_data[7:0] == key) begin
                    n_found = 1'b1;
                    n_state = mrte_pkg::S_RESOLVE;
                end else if (at_end) begin
                    n_found = 1'b0;
                    n_state = mrte_pkg::S_RESOLVE;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = mrte_pkg::S_SRCH_RD;
                end
            end

            // update or add the route where it applies and report it; r_rd_data holds the hit
            mrte_pkg::S_RESOLVE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_state     = mrte_pkg::S_IDLE;
                    n_out.last  = 1'b1;
                    if (r_item.kind == mrte_pkg::KIND_BEACON) begin
                        mem_wdata = mrte_pkg::pack_route(r_item.sender_addr,
                                                         r_item.sender_addr, 8'd1, 8'd0);
                        n_sender  = r_item.sender_addr;
                        n_seen    = r_item.advertised_count;
                        n_open    = (r_item.advertised_count != 8'd0);
                        if (r_found) begin
                            mem_we       = 1'b1;
                            n_out.status = mrte_pkg::ST_UPDATED;
                            {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                             n_out.route_destination} = mem_wdata;
                        end else if (r_total < CW'(D)) begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_total[IW-1:0];
                            n_total      = r_total + CW'(1);
                            n_out.status = mrte_pkg::ST_ADDED;
                            {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                             n_out.route_destination} = mem_wdata;
                        end else begin
                            n_out.status = mrte_pkg::ST_UNCHANGED;
                            {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                             n_out.route_destination} =
                                mrte_pkg::pack_route(r_item.sender_addr, 8'd0, 8'd0, 8'd0);
                        end
                    end else begin
                        if (r_found) begin
                            if (hop_plus < {1'b0, r_rd_data[23:16]}) begin
                                mem_we       = 1'b1;
                                mem_wdata    = mrte_pkg::pack_route(r_item.entry_destination,
                                                   r_sender, hop_plus[7:0], r_rd_data[31:24]);
                                n_out.status = mrte_pkg::ST_UPDATED;
                                {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                                 n_out.route_destination} = mem_wdata;
                            end else begin
                                n_out.status = mrte_pkg::ST_UNCHANGED;
                                {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                                 n_out.route_destination} = r_rd_data;
                            end
                        end else if (r_total < CW'(D) && r_item.entry_hops == 8'd1) begin
                            mem_we       = 1'b1;
                            mem_waddr    = r_total[IW-1:0];
                            mem_wdata    = mrte_pkg::pack_route(r_item.entry_destination,
                                                                r_sender, 8'd2, 8'd1);
                            n_total      = r_total + CW'(1);
                            n_out.status = mrte_pkg::ST_ADDED;
                            {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                             n_out.route_destination} = mem_wdata;
                        end else begin
                            n_out.status = mrte_pkg::ST_IGNORED;
                            {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                             n_out.route_destination} =
                                mrte_pkg::pack_route(r_item.entry_destination,
                                    r_item.entry_next_hop, r_item.entry_hops, 8'd0);
                        end
                    end
                    n_out.used_entries = n_total;
                end
            end

            // dump: one route per result, in table order, or a single empty result if none
            mrte_pkg::S_DUMP_RD: begin
                if (r_total == '0) begin
                    if (slot_free) begin
                        n_out       = '{status: mrte_pkg::ST_EMPTY, route_destination: 8'd0,
                                        route_next_hop: 8'd0, route_hops: 8'd0,
                                        route_age: 8'd0, used_entries: r_total, last: 1'b1};
                        n_out_valid = 1'b1;
                        n_state     = mrte_pkg::S_IDLE;
                    end
                end else begin
                    mem_re  = 1'b1;
                    n_state = mrte_pkg::S_DUMP_EMIT;
                end
            end
            mrte_pkg::S_DUMP_EMIT: begin
                if (slot_free) begin
                    n_out.status = mrte_pkg::ST_DONE;
                    {n_out.route_age, n_out.route_hops, n_out.route_next_hop,
                     n_out.route_destination} = r_rd_data;
                    n_out.used_entries = r_total;
                    n_out.last         = at_end;
                    n_out_valid        = 1'b1;
                    if (at_end) begin
                        n_state = mrte_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + IW'(1);
                        n_state = mrte_pkg::S_DUMP_RD;
                    end
                end
            end

            default: n_state = mrte_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: hdl/mrte_checker.sv
// port-level checks for the mesh routing table engine, bound to the top level
// depends on mrte_pkg and mesh_routing_table_engine
module mrte_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [mrte_pkg::CNT_W-1:0]    i_used,
    input logic                          i_last
);

    // a held result stays offered
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one item at a time
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // no new item while a multi-result item is still listing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input ready in the middle of a listing");

    // the table never reports more routes than it holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_used <= mrte_pkg::CNT_W'(mrte_pkg::TABLE_DEPTH))
        else $error("used entries beyond table depth");

endmodule

bind mesh_routing_table_engine mrte_checker u_mrte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_used      (o_out.item.used_entries),
    .i_last      (o_out.item.last)
);

FILE: tb/sv/tb_mesh_routing_table_engine.sv
// self-checking testbench for the mesh routing table engine
// depends on mrte_pkg, mrte_if and the engine top level
`timescale 1ns / 100ps

class route_scoreboard;
    mrte_pkg::t_out_item pending_results[$];
    int mismatches;

    function new();
        mismatches = 0;
    endfunction

    function void note_item(mrte_pkg::t_out_item r);
        pending_results.push_back(r);
    endfunction

    function void check_result(mrte_pkg::t_out_item got);
        mrte_pkg::t_out_item want;
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = pending_results.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected st=%0d d=%0d n=%0d h=%0d a=%0d u=%0d l=%0d,",
                          " got st=%0d d=%0d n=%0d h=%0d a=%0d u=%0d l=%0d"},
                    want.status, want.route_destination, want.route_next_hop,
                    want.route_hops, want.route_age, want.used_entries, want.last,
                    got.status, got.route_destination, got.route_next_hop,
                    got.route_hops, got.route_age, got.used_entries, got.last);
        end
    endfunction
endclass

module tb_mesh_routing_table_engine;

    logic i_clk = 0;
    logic i_rst_n = 0;
    always #4 i_clk = ~i_clk;

    mrte_in_if  in_ch();
    mrte_out_if out_ch();
    mrte_cfg_if cfg_ch();

    mesh_routing_table_engine u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    route_scoreboard sb = new();

    // predictor state: routes as packed words {age, hops, next hop, dest}
    logic [31:0] routes[mrte_pkg::TABLE_DEPTH];
    int          route_count;
    bit          beacon_live;
    logic [7:0]  beacon_src;
    logic [7:0]  entries_due;
    logic [7:0]  my_addr, timeout_age, top_addr;
    logic signed [7:0] min_rssi;
    bit          idle_off;   // stretch with no random idling

    function automatic mrte_pkg::t_out_item make_result(mrte_pkg::t_status s,
                                                        logic [31:0] w, bit l);
        mrte_pkg::t_out_item r;
        r.status            = s;
        r.route_destination = w[7:0];
        r.route_next_hop    = w[15:8];
        r.route_hops        = w[23:16];
        r.route_age         = w[31:24];
        r.used_entries      = route_count[mrte_pkg::CNT_W-1:0];
        r.last              = l;
        return r;
    endfunction

    function automatic int find_dest(logic [7:0] d);
        for (int i = 0; i < route_count; i++)
            if (routes[i][7:0] == d) return i;
        return -1;
    endfunction

    function automatic bit addr_ok(logic [7:0] a);
        return a >= 1 && a <= top_addr;
    endfunction

    // compute the results of one accepted item and update the routing table
    function automatic void predict_routes(mrte_pkg::t_in_item it);
        int idx;
        mrte_pkg::t_status st;
        logic [8:0] nh;
        logic [31:0] echo;
        logic [7:0] age;
        case (mrte_pkg::t_kind'(it.kind))
            mrte_pkg::KIND_AGE_TICK: begin
                idx = 0;
                while (idx < route_count) begin
                    age = routes[idx][31:24];
                    if (age != 8'hff) age++;
                    routes[idx][31:24] = age;
                    if (age > timeout_age) begin
                        // drop and close the gap
                        for (int j = idx; j + 1 < route_count; j++)
                            routes[j] = routes[j+1];
                        routes[route_count-1] = '0;
                        route_count--;
                    end else idx++;
                end
                sb.note_item(make_result(mrte_pkg::ST_DONE, '0, 1));
            end
            mrte_pkg::KIND_BEACON: begin
                st = mrte_pkg::ST_DONE;
                if (it.advertised_count > mrte_pkg::ADV_LIMIT) st = mrte_pkg::ST_BAD_TABLE;
                else if (it.advertised_count != 0 && !it.table_ok)
                    st = mrte_pkg::ST_BAD_TABLE;
                else if (it.rx_level < min_rssi) st = mrte_pkg::ST_WEAK;
                else if (it.sender_addr == my_addr) st = mrte_pkg::ST_OWN;
                if (st != mrte_pkg::ST_DONE) begin
                    beacon_live = 0;
                    entries_due = 0;
                    sb.note_item(make_result(st, {24'd0, it.sender_addr}, 1));
                end else begin
                    idx = find_dest(it.sender_addr);
                    if (idx >= 0) begin
                        routes[idx] = mrte_pkg::pack_route(it.sender_addr, it.sender_addr,
                                                           8'd1, 8'd0);
                        sb.note_item(make_result(mrte_pkg::ST_UPDATED, routes[idx], 1));
                    end else if (route_count < mrte_pkg::TABLE_DEPTH) begin
                        routes[route_count] = mrte_pkg::pack_route(it.sender_addr,
                                                                   it.sender_addr, 8'd1, 8'd0);
                        route_count++;
                        sb.note_item(make_result(mrte_pkg::ST_ADDED,
                                                 routes[route_count-1], 1));
                    end else
                        sb.note_item(make_result(mrte_pkg::ST_UNCHANGED,
                                                 {24'd0, it.sender_addr}, 1));
                    beacon_src  = it.sender_addr;
                    entries_due = it.advertised_count;
                    beacon_live = it.advertised_count != 0;
                end
            end
            mrte_pkg::KIND_ENTRY: begin
                echo = mrte_pkg::pack_route(it.entry_destination, it.entry_next_hop,
                                            it.entry_hops, 8'd0);
                if (!beacon_live) begin
                    sb.note_item(make_result(mrte_pkg::ST_IGNORED, echo, 1));
                    return;
                end
                if (entries_due != 0) entries_due--;
                if (entries_due == 0) beacon_live = 0;
                if ((it.entry_destination == 0 && it.entry_next_hop == 0 && it.entry_hops == 0)
                    || !addr_ok(it.entry_destination) || !addr_ok(it.entry_next_hop)
                    || it.entry_destination == my_addr) begin
                    sb.note_item(make_result(mrte_pkg::ST_IGNORED, echo, 1));
                    return;
                end
                idx = find_dest(it.entry_destination);
                nh = {1'b0, it.entry_hops} + 9'd1;
                if (idx >= 0) begin
                    if (nh < {1'b0, routes[idx][23:16]}) begin
                        routes[idx] = mrte_pkg::pack_route(it.entry_destination, beacon_src,
                                                           nh[7:0], routes[idx][31:24]);
                        sb.note_item(make_result(mrte_pkg::ST_UPDATED, routes[idx], 1));
                    end else
                        sb.note_item(make_result(mrte_pkg::ST_UNCHANGED, routes[idx], 1));
                end else if (route_count < mrte_pkg::TABLE_DEPTH && it.entry_hops == 1) begin
                    routes[route_count] = mrte_pkg::pack_route(it.entry_destination,
                                                               beacon_src, 8'd2, 8'd1);
                    route_count++;
                    sb.note_item(make_result(mrte_pkg::ST_ADDED, routes[route_count-1], 1));
                end else
                    sb.note_item(make_result(mrte_pkg::ST_IGNORED, echo, 1));
            end
            default: begin
                if (route_count == 0)
                    sb.note_item(make_result(mrte_pkg::ST_EMPTY, '0, 1));
                for (int i = 0; i < route_count; i++)
                    sb.note_item(make_result(mrte_pkg::ST_DONE, routes[i],
                                             i + 1 == route_count));
            end
        endcase
    endfunction

    // result side: random stalls, check at the rising edge
    initial begin
        out_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= idle_off || ($urandom_range(99) >= 18);
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.item);

    // the prediction is made at acceptance; valid then drops at a falling edge before the next item
    task automatic send_item(mrte_pkg::t_in_item it);
        while (!idle_off && $urandom_range(99) < 18)
            @(negedge i_clk);
        in_ch.item  <= it;
        in_ch.valid <= 1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_routes(it);
        @(negedge i_clk);
        in_ch.valid <= 0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        cfg_ch.item  <= '{index: idx, data: val};
        cfg_ch.valid <= 1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            mrte_pkg::CFG_OWN_ADDRESS:      my_addr = val;
            mrte_pkg::CFG_SIGNAL_THRESHOLD: min_rssi = val;
            mrte_pkg::CFG_ROUTE_TIMEOUT:    timeout_age = val;
            mrte_pkg::CFG_HIGHEST_ADDRESS:  top_addr = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 0;
        @(negedge i_clk);
    endtask

    // wait until every expected result came, then let the engine settle
    task automatic drain();
        while (sb.pending_results.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // fully random item bits
    function automatic mrte_pkg::t_in_item noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(mrte_pkg::t_in_item)-1:0];
    endfunction

    function automatic mrte_pkg::t_in_item beacon(logic [7:0] src, logic signed [7:0] rssi,
                                                  logic [7:0] cnt, bit ok);
        mrte_pkg::t_in_item it = '0;
        it.kind = mrte_pkg::KIND_BEACON;
        it.sender_addr = src;
        it.rx_level = rssi;
        it.advertised_count = cnt;
        it.table_ok = ok;
        it.entry_destination = 8'($urandom);
        it.entry_next_hop = 8'($urandom);
        it.entry_hops = 8'($urandom);
        return it;
    endfunction

    function automatic mrte_pkg::t_in_item entry(logic [7:0] d, logic [7:0] n,
                                                 logic [7:0] h);
        mrte_pkg::t_in_item it;
        it = noise_item();
        it.kind = mrte_pkg::KIND_ENTRY;
        it.entry_destination = d;
        it.entry_next_hop = n;
        it.entry_hops = h;
        return it;
    endfunction

    function automatic mrte_pkg::t_in_item simple(mrte_pkg::t_kind k);
        mrte_pkg::t_in_item it;
        it = noise_item();
        it.kind = k;
        return it;
    endfunction

    // small address pool so that entries hit known routes often
    function automatic logic [7:0] pick_addr();
        return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(1, 24));
    endfunction

    task automatic random_phase(int n_items);
        int cnt;
        for (int k = 0; k < n_items; k++) begin
            idle_off = (k >= n_items / 3 && k < n_items / 2);
            case ($urandom_range(9))
                0, 1: send_item(simple(mrte_pkg::KIND_AGE_TICK));
                2:    send_item(simple(mrte_pkg::KIND_DUMP));
                3:    send_item(noise_item());
                default: begin
                    // mostly well-formed beacon with random entries, sometimes cut short
                    cnt = $urandom_range(0, 6);
                    send_item(beacon(pick_addr(), $urandom_range(0, 99) < 85 ?
                                     8'sd10 : 8'($urandom), 8'(cnt),
                                     $urandom_range(9) != 0));
                    for (int e = 0; e < cnt; e++) begin
                        if ($urandom_range(19) == 0) break;
                        send_item(entry(pick_addr(), pick_addr(),
                                        $urandom_range(3) == 0 ? 8'($urandom)
                                                               : 8'($urandom_range(0, 4))));
                        k++;
                    end
                end
            endcase
        end
        idle_off = 0;
    endtask

    initial begin
        in_ch.valid = 0;
        in_ch.item  = '0;
        cfg_ch.valid = 0;
        cfg_ch.item  = '0;
        idle_off = 0;
        route_count = 0;
        beacon_live = 0;
        beacon_src = 0;
        entries_due = 0;
        my_addr = 1;
        min_rssi = -100;
        timeout_age = 5;
        top_addr = 254;
        for (int i = 0; i < mrte_pkg::TABLE_DEPTH; i++) routes[i] = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: empty dump, screening order, entry outside beacon, extremes
        send_item(simple(mrte_pkg::KIND_DUMP));
        send_item(entry(8'd5, 8'd5, 8'd1));
        send_item(beacon(8'd9, 8'sd0, 8'd17, 1));
        send_item(beacon(8'd9, 8'sd0, 8'd3, 0));
        send_item(beacon(8'd9, -8'sd101, 8'd0, 0));
        send_item(beacon(8'd1, 8'sd127, 8'd0, 1));
        send_item(beacon(8'd255, -8'sd100, 8'd16, 1));
        send_item(entry(8'd0, 8'd0, 8'd0));
        send_item(entry(8'd255, 8'd4, 8'd1));
        send_item(entry(8'd1, 8'd4, 8'd1));
        send_item(entry(8'd7, 8'd0, 8'd1));
        send_item(entry(8'd7, 8'd8, 8'd3));
        send_item(entry(8'd7, 8'd8, 8'd1));
        send_item(entry(8'd7, 8'd8, 8'd0));
        send_item(entry(8'd7, 8'd8, 8'd255));
        send_item(beacon(8'd7, 8'sd5, 8'd0, 0));
        send_item(simple(mrte_pkg::KIND_DUMP));
        for (int i = 0; i < 6; i++) send_item(simple(mrte_pkg::KIND_AGE_TICK));
        send_item(simple(mrte_pkg::KIND_DUMP));

        // full table: beacons from fresh senders until it overflows
        for (int i = 0; i < 18; i++) send_item(beacon(8'(40 + i), 8'sd0, 8'd0, 1));
        send_item(beacon(8'd60, 8'sd0, 8'd1, 1));
        send_item(entry(8'd61, 8'd62, 8'd1));
        send_item(simple(mrte_pkg::KIND_DUMP));
        drain();

        random_phase(35);
        drain();
        write_reg(mrte_pkg::CFG_OWN_ADDRESS, 8'd0);
        write_reg(mrte_pkg::CFG_SIGNAL_THRESHOLD, 8'h80);
        write_reg(mrte_pkg::CFG_ROUTE_TIMEOUT, 8'd254);
        write_reg(mrte_pkg::CFG_HIGHEST_ADDRESS, 8'd255);
        random_phase(30);
        drain();
        write_reg(mrte_pkg::CFG_OWN_ADDRESS, 8'd255);
        write_reg(mrte_pkg::CFG_SIGNAL_THRESHOLD, 8'h7f);
        write_reg(mrte_pkg::CFG_ROUTE_TIMEOUT, 8'd0);
        write_reg(mrte_pkg::CFG_HIGHEST_ADDRESS, 8'd1);
        random_phase(15);
        drain();
        write_reg(mrte_pkg::CFG_OWN_ADDRESS, 8'd3);
        write_reg(mrte_pkg::CFG_SIGNAL_THRESHOLD, 8'hf0);
        write_reg(mrte_pkg::CFG_ROUTE_TIMEOUT, 8'd2);
        write_reg(mrte_pkg::CFG_HIGHEST_ADDRESS, 8'd20);
        random_phase(35);
        drain();

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/mrte_pkg.sv
hdl/mrte_if.sv
hdl/mesh_routing_table_engine.sv
hdl/mrte_checker.sv
tb/sv/tb_mesh_routing_table_engine.sv
